// ===== rtl/core/icsp_pkg.sv =====
// shared types, defaults and codes for the serial programming link engine
package icsp_pkg;

  // default link geometry
  localparam int unsigned PAYLOAD_BITS_DEF = 16;
  localparam int unsigned COMMAND_BITS_DEF = 4;
  localparam int unsigned READ_CLOCKS      = 8;

  // timing register widths and reset values
  localparam int unsigned HALF_W   = 8;
  localparam int unsigned TICK_W   = 24;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [HALF_W-1:0] HALF_RST      = 8'd1;
  localparam logic [TICK_W-1:0] PROG_HOLD_RST = 24'd1100;
  localparam logic [TICK_W-1:0] DISCHARGE_RST = 24'd120;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROG_HOLD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISCHARGE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_READ_IDLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIMPLE_MODE = 3'd4;

  // transaction kinds
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_NOP   = 2'd2,
    OP_CMD   = 2'd3
  } op_e;

  // live configuration
  typedef struct packed {
    logic [HALF_W-1:0] half_period_ticks;
    logic [TICK_W-1:0] prog_hold_ticks;
    logic [TICK_W-1:0] discharge_ticks;
    logic              read_idle_level;
    logic              simple_adapter_mode;
  } cfg_t;

  // one result per tick
  typedef struct packed {
    logic       clock_pin;
    logic       data_pin_out;
    logic       data_drive;
    logic       busy_res;
    logic       done_res;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       rejected;
  } res_t;

endpackage

// ===== rtl/core/icsp_ifs.sv =====
// request and result channel interfaces of the serial programming link engine
interface icsp_req_if #(
  parameter int unsigned PAYLOAD_BITS = icsp_pkg::PAYLOAD_BITS_DEF,
  parameter int unsigned COMMAND_BITS = icsp_pkg::COMMAND_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [1:0]              op_kind;
  logic [COMMAND_BITS-1:0] command_code;
  logic [PAYLOAD_BITS-1:0] payload_word;
  logic                    data_pin_in;

  modport source (
    output valid, req_type, op_kind, command_code, payload_word, data_pin_in,
    input  ready
  );
  modport sink (
    input  valid, req_type, op_kind, command_code, payload_word, data_pin_in,
    output ready
  );
endinterface

interface icsp_res_if;
  logic       valid;
  logic       ready;
  logic       clock_pin;
  logic       data_pin_out;
  logic       data_drive;
  logic       busy_res;
  logic       done_res;
  logic       read_valid;
  logic [7:0] read_byte;
  logic       rejected;

  modport source (
    output valid, clock_pin, data_pin_out, data_drive, busy_res, done_res,
           read_valid, read_byte, rejected,
    input  ready
  );
  modport sink (
    input  valid, clock_pin, data_pin_out, data_drive, busy_res, done_res,
           read_valid, read_byte, rejected,
    output ready
  );
endinterface

// ===== rtl/core/icsp_serial_transaction_engine_top.sv =====
// top level of the two-wire serial programming link master
//
//   channel   dir  modport  contents
//   req_i     in   sink     one tick: start flag, kind, command, payload, data pin
//   res_o     out  source   pin levels, busy/done, read byte, rejection
//   cfg_*_i   in   -        register writes, index 0..4, 24-bit data
//
// one request per cycle sustained while the result channel accepts; each request is
// registered in the two-entry queue, then passes through the sequencer into the
// output register. the sequencer's tick update, once per request, sets that rate.
// reset returns the timing registers to their defaults and the link to idle.
// a stalled result holds in the output register; the queue absorbs two more
// requests before ready drops.
module icsp_serial_transaction_engine_top #(
  parameter int unsigned PAYLOAD_BITS = icsp_pkg::PAYLOAD_BITS_DEF,
  parameter int unsigned COMMAND_BITS = icsp_pkg::COMMAND_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  icsp_req_if.sink                             req_i,
  icsp_res_if.source                           res_o,
  input  logic                                 cfg_we_i,
  input  logic [icsp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [icsp_pkg::CFG_W-1:0]           cfg_data_i
);
  import icsp_pkg::*;

  // configuration registers
  cfg_t cfg_q, cfg_d;

  // queue between intake and sequencer
  logic                    q_valid, q_ready, q_start, q_pin;
  op_e                     q_op;
  logic [COMMAND_BITS-1:0] q_cmd;
  logic [PAYLOAD_BITS-1:0] q_pay;
  res_t                    res;

  // register writes, unknown indexes fall through untouched
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HALF_PERIOD: cfg_d.half_period_ticks   = cfg_data_i[HALF_W-1:0];
        REG_PROG_HOLD:   cfg_d.prog_hold_ticks     = cfg_data_i[TICK_W-1:0];
        REG_DISCHARGE:   cfg_d.discharge_ticks     = cfg_data_i[TICK_W-1:0];
        REG_READ_IDLE:   cfg_d.read_idle_level     = cfg_data_i[0];
        REG_SIMPLE_MODE: cfg_d.simple_adapter_mode = cfg_data_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period_ticks   <= HALF_RST;
      cfg_q.prog_hold_ticks     <= PROG_HOLD_RST;
      cfg_q.discharge_ticks     <= DISCHARGE_RST;
      cfg_q.read_idle_level     <= 1'b0;
      cfg_q.simple_adapter_mode <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // intake: classify and queue each request
  icsp_front #(
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .COMMAND_BITS (COMMAND_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (req_i.valid),
    .in_ready_o     (req_i.ready),
    .req_type_i     (req_i.req_type),
    .op_kind_i      (op_e'(req_i.op_kind)),
    .command_code_i (req_i.command_code),
    .payload_word_i (req_i.payload_word),
    .data_pin_in_i  (req_i.data_pin_in),
    .q_valid_o      (q_valid),
    .q_ready_i      (q_ready),
    .q_start_o      (q_start),
    .q_op_o         (q_op),
    .q_cmd_o        (q_cmd),
    .q_pay_o        (q_pay),
    .q_pin_o        (q_pin)
  );

  // sequencer: one link tick per request, result into the output register
  icsp_back #(
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .COMMAND_BITS (COMMAND_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_start_i   (q_start),
    .q_op_i      (q_op),
    .q_cmd_i     (q_cmd),
    .q_pay_i     (q_pay),
    .q_pin_i     (q_pin),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_res_o   (res)
  );

  // result fields onto the channel
  assign res_o.clock_pin    = res.clock_pin;
  assign res_o.data_pin_out = res.data_pin_out;
  assign res_o.data_drive   = res.data_drive;
  assign res_o.busy_res     = res.busy_res;
  assign res_o.done_res     = res.done_res;
  assign res_o.read_valid   = res.read_valid;
  assign res_o.read_byte    = res.read_byte;
  assign res_o.rejected     = res.rejected;

`ifndef SYNTHESIS
  // a rejected start can only meet a running transaction
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.rejected |-> res_o.busy_res)
    else $error("rejection reported while idle");

  // the data line is released only inside a read transaction
  a_release_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.data_drive |-> res_o.busy_res)
    else $error("data line released outside a transaction");

  // the done tick is a busy tick
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.done_res |-> res_o.busy_res)
    else $error("done without busy");

  // a read byte is shown only with read_valid
  a_byte_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.read_byte != 8'd0) |-> res_o.read_valid)
    else $error("read byte without read_valid");
`endif

endmodule

// ===== rtl/core/icsp_front.sv =====
// request intake: classifies each tick and queues it for the engine
module icsp_front #(
  parameter int unsigned PAYLOAD_BITS = icsp_pkg::PAYLOAD_BITS_DEF,
  parameter int unsigned COMMAND_BITS = icsp_pkg::COMMAND_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    req_type_i,
  input  icsp_pkg::op_e           op_kind_i,
  input  logic [COMMAND_BITS-1:0] command_code_i,
  input  logic [PAYLOAD_BITS-1:0] payload_word_i,
  input  logic                    data_pin_in_i,
  output logic                    q_valid_o,
  input  logic                    q_ready_i,
  output logic                    q_start_o,
  output icsp_pkg::op_e           q_op_o,
  output logic [COMMAND_BITS-1:0] q_cmd_o,
  output logic [PAYLOAD_BITS-1:0] q_pay_o,
  output logic                    q_pin_o
);
  import icsp_pkg::*;

  localparam int unsigned DEPTH = 2;

  logic                    ent_start_q [DEPTH];
  op_e                     ent_op_q    [DEPTH];
  logic [COMMAND_BITS-1:0] ent_cmd_q   [DEPTH];
  logic [PAYLOAD_BITS-1:0] ent_pay_q   [DEPTH];
  logic                    ent_pin_q   [DEPTH];

  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  logic [COMMAND_BITS-1:0] cmd_cls;
  logic [PAYLOAD_BITS-1:0] pay_cls;

  // a nop sends zero command bits, only a write carries its payload
  assign cmd_cls = (op_kind_i == OP_NOP) ? '0 : command_code_i;
  assign pay_cls = (op_kind_i == OP_WRITE) ? payload_word_i : '0;

  assign in_ready_o = (cnt_q != 2'(DEPTH));
  assign q_valid_o  = (cnt_q != 2'd0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  assign q_start_o = ent_start_q[rd_ptr_q];
  assign q_op_o    = ent_op_q[rd_ptr_q];
  assign q_cmd_o   = ent_cmd_q[rd_ptr_q];
  assign q_pay_o   = ent_pay_q[rd_ptr_q];
  assign q_pin_o   = ent_pin_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_start_q[wr_ptr_q] <= req_type_i;
      ent_op_q[wr_ptr_q]    <= op_kind_i;
      ent_cmd_q[wr_ptr_q]   <= cmd_cls;
      ent_pay_q[wr_ptr_q]   <= pay_cls;
      ent_pin_q[wr_ptr_q]   <= data_pin_in_i;
    end
  end

endmodule

// ===== rtl/core/icsp_back.sv =====
// pin sequencer: runs the transactions one tick per queued request
module icsp_back #(
  parameter int unsigned PAYLOAD_BITS = icsp_pkg::PAYLOAD_BITS_DEF,
  parameter int unsigned COMMAND_BITS = icsp_pkg::COMMAND_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  icsp_pkg::cfg_t          cfg_i,
  input  logic                    q_valid_i,
  output logic                    q_ready_o,
  input  logic                    q_start_i,
  input  icsp_pkg::op_e           q_op_i,
  input  logic [COMMAND_BITS-1:0] q_cmd_i,
  input  logic [PAYLOAD_BITS-1:0] q_pay_i,
  input  logic                    q_pin_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output icsp_pkg::res_t          out_res_o
);
  import icsp_pkg::*;

  localparam int unsigned BW = $clog2(PAYLOAD_BITS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CMD   = 3'd1;
  localparam logic [2:0] ST_GAP   = 3'd2;
  localparam logic [2:0] ST_PAY   = 3'd3;
  localparam logic [2:0] ST_RIDLE = 3'd4;
  localparam logic [2:0] ST_RBITS = 3'd5;
  localparam logic [2:0] ST_DIS   = 3'd6;

  function automatic logic two_halves(input logic [2:0] s);
    return (s == ST_CMD) || (s == ST_PAY) || (s == ST_RIDLE) || (s == ST_RBITS);
  endfunction

  logic [2:0]              stage_q, stage_d, stage_e, stage_nx;
  logic [BW-1:0]           bit_q, bit_d, bit_e, bit_inc, bits_lim;
  logic [TICK_W-1:0]       tick_q, tick_d, tick_e, tick_inc, half_len;
  logic [PAYLOAD_BITS-1:0] sw_q, sw_d;
  logic [COMMAND_BITS-1:0] cmd_q, cmd_d, cmd_sh;
  op_e                     op_q, op_d;
  logic [7:0]              racc_q, racc_d;
  logic                    clk_q, clk_d, clk_e;
  logic                    out_valid_q;
  res_t                    res_q, res_d;
  logic                    fire, start, busy;

  assign q_ready_o   = !out_valid_q || out_ready_i;
  assign fire        = q_valid_i && q_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  always_comb begin
    stage_d = stage_q;
    bit_d   = bit_q;
    tick_d  = tick_q;
    sw_d    = sw_q;
    cmd_d   = cmd_q;
    op_d    = op_q;
    racc_d  = racc_q;
    clk_d   = clk_q;
    res_d   = '0;

    // start request: load the new transaction before the tick is shown
    start   = q_start_i && (stage_q == ST_IDLE);
    stage_e = stage_q;
    bit_e   = bit_q;
    tick_e  = tick_q;
    clk_e   = clk_q;
    if (start) begin
      op_d    = q_op_i;
      cmd_d   = q_cmd_i;
      sw_d    = q_pay_i;
      racc_d  = 8'd0;
      stage_e = ST_CMD;
      bit_e   = '0;
      tick_e  = '0;
      clk_e   = 1'b1;
    end
    stage_d = stage_e;
    bit_d   = bit_e;
    tick_d  = tick_e;
    clk_d   = clk_e;

    busy   = (stage_e != ST_IDLE);
    cmd_sh = cmd_d >> bit_e;

    res_d.rejected     = q_start_i && (stage_q != ST_IDLE);
    res_d.busy_res     = busy;
    res_d.clock_pin    = busy && clk_e;
    res_d.data_pin_out = !cfg_i.simple_adapter_mode;
    res_d.data_drive   = 1'b1;
    if (busy) begin
      unique case (stage_e)
        ST_CMD:   res_d.data_pin_out = cmd_sh[0];
        ST_GAP:   res_d.data_pin_out = cmd_d[COMMAND_BITS-1];
        ST_PAY:   res_d.data_pin_out = sw_d[0];
        ST_RIDLE: res_d.data_pin_out = cfg_i.read_idle_level;
        ST_RBITS: begin
          res_d.data_pin_out = clk_e ? cfg_i.read_idle_level
                                     : !cfg_i.simple_adapter_mode;
          res_d.data_drive   = 1'b0;
        end
        default:  res_d.data_pin_out = 1'b0;
      endcase
    end

    // length of the current half period, zero counts as one tick
    priority if (stage_e == ST_DIS) begin
      half_len = (cfg_i.discharge_ticks == '0) ? TICK_W'(1) : cfg_i.discharge_ticks;
    end else if (stage_e == ST_CMD && op_d == OP_NOP && clk_e &&
                 bit_e == BW'(COMMAND_BITS - 1)) begin
      half_len = (cfg_i.prog_hold_ticks == '0) ? TICK_W'(1) : cfg_i.prog_hold_ticks;
    end else begin
      half_len = (cfg_i.half_period_ticks == '0) ? TICK_W'(1)
                                                 : TICK_W'(cfg_i.half_period_ticks);
    end

    unique case (stage_e)
      ST_CMD:             bits_lim = BW'(COMMAND_BITS);
      ST_PAY:             bits_lim = BW'(PAYLOAD_BITS);
      ST_RIDLE, ST_RBITS: bits_lim = BW'(READ_CLOCKS);
      default:            bits_lim = BW'(1);
    endcase

    unique case (stage_e)
      ST_CMD: begin
        unique case (op_d)
          OP_WRITE: stage_nx = ST_GAP;
          OP_READ:  stage_nx = ST_RIDLE;
          OP_NOP:   stage_nx = ST_DIS;
          default:  stage_nx = ST_IDLE;
        endcase
      end
      ST_GAP, ST_DIS: stage_nx = ST_PAY;
      ST_RIDLE:       stage_nx = ST_RBITS;
      default:        stage_nx = ST_IDLE;
    endcase

    tick_inc = tick_e + TICK_W'(1);
    bit_inc  = bit_e + BW'(1);

    if (busy) begin
      if (tick_inc < half_len && tick_inc != '0) begin
        tick_d = tick_inc;
      end else begin
        tick_d = '0;
        if (clk_e && two_halves(stage_e)) begin
          // end of a high half: sample during read bits
          if (stage_e == ST_RBITS) begin
            racc_d = racc_d | (8'(q_pin_i) << bit_e[2:0]);
          end
          clk_d = 1'b0;
        end else begin
          if (stage_e == ST_PAY) begin
            sw_d = sw_d >> 1;
          end
          if (bit_inc >= bits_lim) begin
            stage_d = stage_nx;
            bit_d   = '0;
            clk_d   = two_halves(stage_nx);
          end else begin
            bit_d = bit_inc;
            clk_d = two_halves(stage_e);
          end
        end
      end
    end

    res_d.done_res   = busy && (stage_d == ST_IDLE);
    res_d.read_valid = (stage_d == ST_IDLE) && (op_d == OP_READ);
    res_d.read_byte  = res_d.read_valid ? racc_d : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= ST_IDLE;
      bit_q       <= '0;
      tick_q      <= '0;
      sw_q        <= '0;
      cmd_q       <= '0;
      op_q        <= OP_WRITE;
      racc_q      <= 8'd0;
      clk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        stage_q <= stage_d;
        bit_q   <= bit_d;
        tick_q  <= tick_d;
        sw_q    <= sw_d;
        cmd_q   <= cmd_d;
        op_q    <= op_d;
        racc_q  <= racc_d;
        clk_q   <= clk_d;
      end
      if (q_ready_o) begin
        out_valid_q <= q_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

endmodule
